>>> hdl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared constants for the Halton point scaler: the prime base table, field
// widths and parameter defaults.
// ----------------------------------------------------------------------------
package hps_pkg;

  // Widths of the fixed transaction fields.
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned VAL_W  = 32;
  // The largest prime in the table needs nine bits.
  localparam int unsigned BASE_W = 9;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_DIM_DEF    = 16;
  localparam int unsigned INDEX_BITS_DEF = 20;
  localparam int unsigned FRAC_BITS_DEF  = 32;

  // The first 64 primes, one base per dimension.
  localparam logic [BASE_W-1:0] PRIME_TABLE [0:63] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

endpackage

>>> hdl/halton_point_scaler.sv
// ----------------------------------------------------------------------------
// halton_point_scaler
// One coordinate of a Halton point per transaction, scaled to the bounds.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  -------------------------------------------
//   in       in_valid / in_stall     point_index, dimension, lower_bound,
//                                    upper_bound
//   out      out_valid / out_stall   coordinate, unit_value
//
// A transaction may enter on every cycle while in_stall is low. The pipeline
// is 2*INDEX_BITS + FRAC_BITS + 3 register stages deep (75 with the defaults).
// Each base digit of the index takes two stages (reciprocal multiply, then
// remainder and accumulation), each quotient bit of the restoring division one.
// Reset clears only the valid bits; the data registers are left as they are.
// When the output holds a transaction and out_stall is high, the whole pipeline
// freezes and in_stall is raised, so nothing is dropped or repeated.
//
// Flow: the dimension (taken modulo MAX_DIM) selects a prime base b and a
// reciprocal floor(2^INDEX_BITS / b). Each digit stage divides the remaining
// index by b through that reciprocal plus one correction step, appends the
// remainder to the reversed value R and multiplies the power P by b. Once the
// index reaches zero the later digit stages just pass the values on. The
// division stages then form t = floor(R * 2^FRAC_BITS / P) one bit a stage,
// t is aligned to a 0.32 fraction u, and the final two stages compute
// lower_bound + floor(u * (upper_bound - lower_bound) / 2^32).
module halton_point_scaler
  import hps_pkg::*;
#(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [INDEX_BITS-1:0]   point_index,
  input  logic [DIM_W-1:0]        dimension,
  input  logic signed [VAL_W-1:0] lower_bound,
  input  logic signed [VAL_W-1:0] upper_bound,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] coordinate,
  output logic [VAL_W-1:0]        unit_value
);

  // R and P stay below 2^INDEX_BITS times the largest base.
  localparam int unsigned PW_W   = INDEX_BITS + BASE_W;
  localparam int unsigned D_END  = 2 * INDEX_BITS;
  localparam int unsigned V_END  = D_END + FRAC_BITS;
  localparam int unsigned M_POS  = V_END + 1;
  localparam int unsigned LAST   = V_END + 2;
  localparam int unsigned N_DIMS = 1 << DIM_W;

  // Per-dimension base and reciprocal, fixed at elaboration.
  logic [BASE_W-1:0]     base_tab  [N_DIMS];
  logic [INDEX_BITS-1:0] recip_tab [N_DIMS];

  for (genvar v = 0; v < N_DIMS; v++) begin : g_tab
    localparam int unsigned DSEL = v % MAX_DIM;
    localparam longint unsigned RECIP =
      (longint'(1) << INDEX_BITS) / longint'(PRIME_TABLE[DSEL]);
    assign base_tab[v]  = PRIME_TABLE[DSEL];
    assign recip_tab[v] = RECIP[INDEX_BITS-1:0];
  end

  // Pipeline registers, one entry per stage.
  logic                  vld   [0:LAST];
  logic [VAL_W-1:0]      lo    [0:LAST];
  logic [VAL_W:0]        span  [0:LAST];
  logic [BASE_W-1:0]     base  [0:LAST];
  logic [INDEX_BITS-1:0] recip [0:LAST];
  logic [INDEX_BITS-1:0] idx   [0:LAST];
  logic [INDEX_BITS-1:0] q0    [0:LAST];
  logic [PW_W-1:0]       rev   [0:LAST];
  logic [PW_W-1:0]       pw    [0:LAST];
  logic [PW_W:0]         rem   [0:LAST];
  logic [FRAC_BITS-1:0]  quo   [0:LAST];
  logic [2*VAL_W:0]      prod;
  logic [VAL_W-1:0]      unit_m;
  logic                  adv;

  // The pipeline moves as one unless the output is held.
  assign adv       = !(vld[LAST] && out_stall);
  assign in_stall  = vld[LAST] && out_stall;
  assign out_valid = vld[LAST];

  // Entry stage: capture the transaction and look up the base.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo[0]    <= lower_bound;
      span[0]  <= {upper_bound[VAL_W-1], upper_bound} - {lower_bound[VAL_W-1], lower_bound};
      base[0]  <= base_tab[dimension];
      recip[0] <= recip_tab[dimension];
      idx[0]   <= point_index;
      q0[0]    <= '0;
      rev[0]   <= '0;
      pw[0]    <= PW_W'(1);
      rem[0]   <= '0;
      quo[0]   <= '0;
    end
  end

  for (genvar p = 1; p <= LAST; p++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[p] <= 1'b0;
      end else if (adv) begin
        vld[p] <= vld[p-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lo[p]    <= lo[p-1];
        span[p]  <= span[p-1];
        base[p]  <= base[p-1];
        recip[p] <= recip[p-1];
      end
    end

    if (p <= D_END && (p % 2) == 1) begin : g_dig_a
      // First half of a digit: estimate the quotient by the reciprocal.
      logic [2*INDEX_BITS-1:0] est;
      assign est = (2*INDEX_BITS)'(idx[p-1]) * (2*INDEX_BITS)'(recip[p-1]);
      always_ff @(posedge clk) begin
        if (adv) begin
          q0[p]  <= est[2*INDEX_BITS-1:INDEX_BITS];
          idx[p] <= idx[p-1];
          rev[p] <= rev[p-1];
          pw[p]  <= pw[p-1];
          rem[p] <= rem[p-1];
          quo[p] <= quo[p-1];
        end
      end
    end else if (p <= D_END) begin : g_dig_b
      // Second half: correct the estimate by one, take the digit, append it.
      logic [INDEX_BITS+BASE_W-1:0] qb;
      logic [INDEX_BITS-1:0]        rr;
      logic                         over;
      logic [INDEX_BITS-1:0]        dig;
      logic [INDEX_BITS-1:0]        qn;
      assign qb   = (INDEX_BITS+BASE_W)'(q0[p-1]) * (INDEX_BITS+BASE_W)'(base[p-1]);
      assign rr   = idx[p-1] - qb[INDEX_BITS-1:0];
      // Compared at full width so that a base wider than the index still works.
      assign over = (INDEX_BITS+BASE_W)'(rr) >= (INDEX_BITS+BASE_W)'(base[p-1]);
      assign dig  = over ? rr - INDEX_BITS'(base[p-1]) : rr;
      assign qn   = over ? q0[p-1] + INDEX_BITS'(1) : q0[p-1];
      always_ff @(posedge clk) begin
        if (adv) begin
          q0[p]  <= q0[p-1];
          rem[p] <= rem[p-1];
          quo[p] <= quo[p-1];
          if (idx[p-1] != '0) begin
            idx[p] <= qn;
            rev[p] <= PW_W'(rev[p-1] * PW_W'(base[p-1])) + PW_W'(dig);
            pw[p]  <= PW_W'(pw[p-1] * PW_W'(base[p-1]));
          end else begin
            idx[p] <= idx[p-1];
            rev[p] <= rev[p-1];
            pw[p]  <= pw[p-1];
          end
        end
      end
    end else if (p <= V_END) begin : g_div
      // One restoring division step per stage; the first one starts from R.
      logic [PW_W:0] cur;
      logic [PW_W:0] sh;
      logic          ge;
      assign cur = (p == D_END + 1) ? {1'b0, rev[p-1]} : rem[p-1];
      assign sh  = {cur[PW_W-1:0], 1'b0};
      assign ge  = sh >= {1'b0, pw[p-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          idx[p] <= idx[p-1];
          q0[p]  <= q0[p-1];
          rev[p] <= rev[p-1];
          pw[p]  <= pw[p-1];
          rem[p] <= ge ? sh - {1'b0, pw[p-1]} : sh;
          quo[p] <= {quo[p-1][FRAC_BITS-2:0], ge};
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (adv) begin
          idx[p] <= idx[p-1];
          q0[p]  <= q0[p-1];
          rev[p] <= rev[p-1];
          pw[p]  <= pw[p-1];
          rem[p] <= rem[p-1];
          quo[p] <= quo[p-1];
        end
      end
    end
  end

  // Align the quotient to a 0.32 fraction.
  logic [VAL_W-1:0] u_al;
  if (FRAC_BITS >= VAL_W) begin : g_al_tr
    assign u_al = quo[V_END][FRAC_BITS-1 -: VAL_W];
  end else begin : g_al_zf
    assign u_al = {quo[V_END], {(VAL_W-FRAC_BITS){1'b0}}};
  end

  // Scaling multiply by the magnitude of the span.
  logic [VAL_W:0] mag;
  assign mag = span[V_END][VAL_W] ? (~span[V_END] + (VAL_W+1)'(1)) : span[V_END];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= (2*VAL_W+1)'(u_al) * (2*VAL_W+1)'(mag);
      unit_m <= u_al;
    end
  end

  // Output stage: floor division by 2^32 and offset by the lower bound.
  logic [2*VAL_W+1:0] up;
  logic [VAL_W-1:0]   qv;
  assign up = {1'b0, prod} + (2*VAL_W+2)'(32'hFFFF_FFFF);
  assign qv = span[M_POS][VAL_W] ? (~up[2*VAL_W-1:VAL_W] + VAL_W'(1))
                                 : prod[2*VAL_W-1:VAL_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      coordinate <= lo[M_POS] + qv;
      unit_value <= unit_m;
    end
  end

  // The input is only held back while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A frozen pipeline keeps its output transaction.
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(unit_value) && $stable(coordinate)))
    else $error("held result changed");

  // The reversed digits stay below the power when division starts.
  a_rev_lt_pw: assert property (@(posedge clk) disable iff (rst)
    vld[D_END] |-> (rev[D_END] < pw[D_END]))
    else $error("reversed value not below power");

endmodule

>>> sim/tb_halton_point_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_halton_point_scaler
// Self-checking bench for the Halton point scaler. Directed and random
// transactions are sent under several idle and stall patterns; a predictor
// computes the radical inverse and the scaled coordinate of each one, and a
// checker compares every output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_halton_point_scaler
  import hps_pkg::*;
;

  localparam int unsigned IDX_W   = INDEX_BITS_DEF;
  // Pipeline depth given by the block.
  localparam int unsigned LATENCY = 2 * INDEX_BITS_DEF + FRAC_BITS_DEF + 3;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [VAL_W-1:0] coord;
    logic [VAL_W-1:0]        unit;
  } halton_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [IDX_W-1:0] point_index;
  logic [DIM_W-1:0] dimension;
  logic signed [VAL_W-1:0] lower_bound;
  logic signed [VAL_W-1:0] upper_bound;
  logic out_valid;
  logic out_stall;
  logic signed [VAL_W-1:0] coordinate;
  logic [VAL_W-1:0] unit_value;

  halton_result_t pending_results[$];
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned error_count = 0;
  int unsigned sent_count;
  int unsigned checked_count = 0;
  int unsigned quiet_cycles = 0;

  halton_point_scaler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_index(point_index), .dimension(dimension),
    .lower_bound(lower_bound), .upper_bound(upper_bound),
    .out_valid(out_valid), .out_stall(out_stall),
    .coordinate(coordinate), .unit_value(unit_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Radical inverse of the index in the dimension's prime base, then a
  // restoring division to a 0.32 fraction and scaling between the bounds.
  function automatic halton_result_t predict_coordinate(
      logic [IDX_W-1:0] idx_in, logic [DIM_W-1:0] dim_in,
      logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi);
    longint unsigned idx;
    longint unsigned base;
    longint unsigned rev;
    longint unsigned pw;
    longint unsigned rem;
    longint unsigned quo;
    longint unsigned mag;
    longint signed span;
    longint signed step;
    halton_result_t res;
    idx  = idx_in;
    base = PRIME_TABLE[dim_in % MAX_DIM_DEF];
    rev  = 0;
    pw   = 1;
    quo  = 0;
    while (idx > 0) begin
      rev = rev * base + (idx % base);
      pw  = pw * base;
      idx = idx / base;
    end
    rem = rev;
    for (int b = 0; b < FRAC_BITS_DEF; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= pw) begin
        rem = rem - pw;
        quo = quo | 64'd1;
      end
    end
    quo  = quo & 64'hFFFF_FFFF;
    span = longint'(hi) - longint'(lo);
    // Floor division by 2^32: a negative span rounds away from zero.
    if (span >= 0) begin
      step = longint'((quo * longint'(span)) >> 32);
    end else begin
      mag  = quo * longint'(-span);
      step = -longint'((mag + 64'hFFFF_FFFF) >> 32);
    end
    res.coord = VAL_W'(longint'(lo) + step);
    res.unit  = quo[VAL_W-1:0];
    return res;
  endfunction

  // Sends one transaction, with a random idle gap before it, and records the
  // prediction when it is accepted.
  task automatic send_point(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] dim,
                            logic signed [VAL_W-1:0] lo,
                            logic signed [VAL_W-1:0] hi);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    point_index <= idx;
    dimension   <= dim;
    lower_bound <= lo;
    upper_bound <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, predict_coordinate(idx, dim, lo, hi)};
    sent_count++;
    @(negedge clk);
  endtask

  // Lowers valid once a burst of transactions is done.
  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Checker: compares every accepted output transaction with the oldest
  // prediction, and counts cycles in which nothing moves.
  always @(posedge clk) begin
    halton_result_t exp_res;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("output transaction with no prediction waiting: coordinate %h",
                 coordinate);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          checked_count++;
          if (coordinate !== exp_res.coord) begin
            $error("coordinate: expected %h, actual %h", exp_res.coord, coordinate);
            error_count++;
          end
          if (unit_value !== exp_res.unit) begin
            $error("unit_value: expected %h, actual %h", exp_res.unit, unit_value);
            error_count++;
          end
        end
      end
    end
  end

  // Ends the run when the pipeline makes no progress for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Bounds, extremes, index zero, every dimension, and reversed bounds.
  task automatic test_directed();
    send_point('0, 4'd0, 32'sh0001_0000, 32'sh0002_0000);
    send_point(20'd1, 4'd0, 32'sh0000_0000, 32'sh0001_0000);
    send_point('1, 4'd15, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point('1, 4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point('1, 4'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(20'h80000, 4'd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(20'd5, 4'd2, 32'shFFFF_0000, 32'shFFFF_0000);
    send_point(20'd7, 4'd3, 32'sh0010_0000, 32'shFFF0_0000);
    for (int d = 0; d < 16; d++) begin
      send_point(IDX_W'(d + 1), DIM_W'(d), -32'sd65536, 32'sd65536);
    end
    end_burst();
  endtask

  // Random transactions; small indices are common so that short digit strings
  // get exercised as well as the full twenty bits.
  task automatic test_random(int unsigned count);
    logic [IDX_W-1:0] idx;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: idx = IDX_W'($urandom_range(40));
        1: idx = IDX_W'($urandom_range(4095));
        default: idx = IDX_W'($urandom);
      endcase
      lo = $urandom;
      hi = ($urandom_range(3) == 0) ? VAL_W'($urandom) : lo + $signed(VAL_W'($urandom_range(32'h00FF_FFFF)));
      send_point(idx, DIM_W'($urandom), lo, hi);
    end
    end_burst();
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    point_index  = '0;
    dimension    = '0;
    lower_bound  = '0;
    upper_bound  = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    sent_count   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(500);
    idle_pct = 47; stall_pct = 0;
    test_random(400);
    idle_pct = 0; stall_pct = 47;
    test_random(400);
    idle_pct = 29; stall_pct = 29;
    test_random(400);
    wait_drained();

    $display("Sent %0d transactions under four idle/stall patterns; %0d results checked.",
             sent_count, checked_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
